[rtl/eec_pkg.sv]
// Package for the extended Euclid unit: sequencer state type.
package eec_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_UPDATE,
        ST_FINISH
    } eec_state_t;

endpackage

[rtl/extended_euclid_coefficient.sv]
// Extended Euclid unit: Bezout coefficient of operand a plus the gcd.
//
// Input channel s_*: one beat carries operand_a and operand_b, each
// DATA_WIDTH-1 bits unsigned. Result channel m_*: one beat carries
// bezout_s (DATA_WIDTH bits, two's complement) and gcd_value
// (DATA_WIDTH-1 bits), with a*s + b*t = gcd(a,b). Each input beat yields
// exactly one result beat.
//
// One item is worked on at a time. Every Euclid step is a restoring
// division done one quotient bit per cycle. The product q*s is built in
// the same pass by shift-and-add, followed by the update state and the
// zero-test state. The number of Euclid steps k is at most about 46 at
// the default width, and k is 0 when operand_b is zero.
//
// aresetn is synchronous, active low; it drops any item in flight and any
// pending result. The result sits in an output register: while the
// receiver stalls, s_ready comes back once the next item may start, and
// a finished item waits until the output register is free.
module extended_euclid_coefficient
    import eec_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DATA_WIDTH-2:0] s_operand_a,
    input  logic [DATA_WIDTH-2:0] s_operand_b,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_WIDTH-1:0] m_bezout_s,
    output logic [DATA_WIDTH-2:0] m_gcd_value
);

    localparam int OpW  = DATA_WIDTH - 1;
    localparam int CntW = $clog2(OpW);
    localparam logic [CntW-1:0] LastCnt = CntW'(OpW - 1);

    eec_state_t state_reg, state_next;

    logic [OpW-1:0]        rp_reg, rc_reg;     // previous / current remainder
    logic [DATA_WIDTH-1:0] cp_reg, cc_reg;     // previous / current coefficient
    logic [DATA_WIDTH-1:0] prod_reg;           // q * cc built MSB first
    logic [OpW-1:0]        dvd_reg;            // dividend shift register
    logic [OpW-1:0]        pr_reg;             // partial remainder
    logic [CntW-1:0]       cnt_reg;

    logic                  m_valid_reg;
    logic [DATA_WIDTH-1:0] m_bezout_s_reg;
    logic [OpW-1:0]        m_gcd_value_reg;

    logic [OpW:0]          trial;
    logic                  q_bit;
    logic                  out_load;

    assign trial = {pr_reg, dvd_reg[OpW-1]} - {1'b0, rc_reg};
    assign q_bit = ~trial[OpW];

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (rc_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (cnt_reg == '0) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = ST_CHECK;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rp_reg <= s_operand_a;
                    rc_reg <= s_operand_b;
                    cp_reg <= DATA_WIDTH'(1);
                    cc_reg <= '0;
                end
            end
            ST_CHECK: begin
                dvd_reg  <= rp_reg;
                pr_reg   <= '0;
                prod_reg <= '0;
                cnt_reg  <= LastCnt;
            end
            ST_DIVIDE: begin
                dvd_reg  <= {dvd_reg[OpW-2:0], 1'b0};
                pr_reg   <= q_bit ? trial[OpW-1:0] : {pr_reg[OpW-2:0], dvd_reg[OpW-1]};
                prod_reg <= {prod_reg[DATA_WIDTH-2:0], 1'b0} + (q_bit ? cc_reg : '0);
                cnt_reg  <= cnt_reg - CntW'(1);
            end
            ST_UPDATE: begin
                rp_reg <= rc_reg;
                rc_reg <= pr_reg;
                cp_reg <= cc_reg;
                cc_reg <= cp_reg - prod_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_bezout_s_reg  <= cp_reg;
            m_gcd_value_reg <= rp_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_bezout_s  = m_bezout_s_reg;
    assign m_gcd_value = m_gcd_value_reg;

endmodule

[rtl/eec_checker.sv]
// Port-level checks for the extended Euclid unit, bound to the top level.
module eec_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [DATA_WIDTH-2:0] s_operand_a,
    input logic [DATA_WIDTH-2:0] s_operand_b,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [DATA_WIDTH-1:0] m_bezout_s,
    input logic [DATA_WIDTH-2:0] m_gcd_value
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat present after reset");

    // one item at a time: no accept right after an accept
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while previous item still running");

    // gcd is zero only for two zero operands, and then s is one
    a_zero_gcd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_gcd_value == '0) |-> (m_bezout_s == DATA_WIDTH'(1)))
        else $error("zero gcd with coefficient other than one");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_bezout_s) && $stable(m_gcd_value)))
        else $error("stalled result beat changed or dropped");

    // a waiting input beat keeps its operands
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=>
            (s_valid && $stable(s_operand_a) && $stable(s_operand_b)))
        else $error("waiting input beat changed or dropped");

endmodule

bind extended_euclid_coefficient eec_checker #(.DATA_WIDTH(DATA_WIDTH)) u_eec_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_operand_a (s_operand_a),
    .s_operand_b (s_operand_b),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_bezout_s  (m_bezout_s),
    .m_gcd_value (m_gcd_value)
);

[tb/tb_top.sv]
// Testbench for extended_euclid_coefficient: Bezout coefficient and gcd checks.
`timescale 1ns / 100ps

module tb_top;

    localparam int DW  = 32;
    localparam int OPW = DW - 1;
    localparam logic [OPW-1:0] OP_MAX = '1;

    typedef struct {
        logic [OPW-1:0] a;
        logic [OPW-1:0] b;
        logic [DW-1:0]  coef;
        logic [OPW-1:0] gcd;
    } bezout_expect_t;

    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_RARE
    } ready_mode_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    logic [OPW-1:0] s_operand_a = '0;
    logic [OPW-1:0] s_operand_b = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    logic [DW-1:0]  m_bezout_s;
    logic [OPW-1:0] m_gcd_value;

    bezout_expect_t expected_coefs[$];
    int             error_count = 0;
    int             burst_left = 0;
    ready_mode_t    ready_mode = RDY_ALWAYS;
    int             ready_phase_left = 0;

    extended_euclid_coefficient #(
        .DATA_WIDTH(DW)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_operand_a(s_operand_a),
        .s_operand_b(s_operand_b),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_bezout_s (m_bezout_s),
        .m_gcd_value(m_gcd_value)
    );

    always #5 aclk = ~aclk;

    // Extended Euclid with 64-bit wraparound on the coefficient chain
    function automatic bezout_expect_t predict_bezout(logic [OPW-1:0] a, logic [OPW-1:0] b);
        bezout_expect_t r;
        logic [63:0]    rem_old;
        logic [63:0]    rem_now;
        logic [63:0]    rem_new;
        logic [63:0]    s_old;
        logic [63:0]    s_now;
        logic [63:0]    s_new;
        logic [63:0]    quot;
        rem_old = 64'(a);
        rem_now = 64'(b);
        s_old = 64'd1;
        s_now = 64'd0;
        while (rem_now != 64'd0) begin
            quot = rem_old / rem_now;
            rem_new = rem_old - quot * rem_now;
            s_new = s_old - quot * s_now;
            rem_old = rem_now;
            rem_now = rem_new;
            s_old = s_now;
            s_now = s_new;
        end
        r.a = a;
        r.b = b;
        r.coef = s_old[DW-1:0];
        r.gcd = rem_old[OPW-1:0];
        return r;
    endfunction

    // value with a random bit length, so magnitudes spread evenly
    function automatic logic [OPW-1:0] random_operand();
        int          bits;
        logic [63:0] mask;
        bits = $urandom_range(1, OPW);
        mask = (64'd1 << bits) - 64'd1;
        return OPW'(64'($urandom) & mask);
    endfunction

    function automatic logic [63:0] fibonacci(int n);
        logic [63:0] f0;
        logic [63:0] f1;
        logic [63:0] t;
        f0 = 64'd0;
        f1 = 64'd1;
        for (int i = 0; i < n; i++) begin
            t = f0 + f1;
            f0 = f1;
            f1 = t;
        end
        return f0;
    endfunction

    // sender: bursts of back-to-back beats, random gaps in between
    task automatic send_operands(logic [OPW-1:0] a, logic [OPW-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            else if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(1, 2000);
            else
                gap = $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_operand_a <= a;
        s_operand_b <= b;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic test_zero_operands();
        send_operands('0, '0);
        send_operands(OPW'(12345), '0);
        send_operands('0, OPW'(777));
        send_operands(OP_MAX, '0);
        send_operands('0, OP_MAX);
        send_operands(OPW'(1), '0);
        send_operands('0, OPW'(1));
    endtask

    task automatic test_extremes();
        send_operands(OP_MAX, OP_MAX);
        send_operands(OP_MAX, OPW'(1));
        send_operands(OPW'(1), OP_MAX);
        send_operands(OPW'(1), OPW'(1));
        send_operands(OP_MAX, OP_MAX - OPW'(1));
        send_operands(OPW'(1) << (OPW - 1), OP_MAX);
        send_operands(OPW'(1) << (OPW - 1), OPW'(1) << 10);
        send_operands(OPW'(17), OPW'(3120));
        send_operands(OPW'(240), OPW'(46));
        send_operands(OPW'('h2AAA_AAAA), OPW'('h5555_5555));
    endtask

    // consecutive Fibonacci numbers give the longest Euclid chains
    task automatic test_fibonacci_worst();
        send_operands(OPW'(fibonacci(46)), OPW'(fibonacci(45)));
        send_operands(OPW'(fibonacci(45)), OPW'(fibonacci(46)));
        send_operands(OPW'(fibonacci(30)), OPW'(fibonacci(29)));
    endtask

    task automatic test_random_operands(int count);
        logic [OPW-1:0] a;
        logic [OPW-1:0] b;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                a = OPW'($urandom);
                b = OPW'($urandom);
            end else begin
                a = random_operand();
                b = random_operand();
            end
            send_operands(a, b);
        end
    endtask

    task automatic test_small_operands(int count);
        for (int i = 0; i < count; i++)
            send_operands(OPW'($urandom_range(0, 255)), OPW'($urandom_range(0, 255)));
    endtask

    task automatic test_shared_factor(int count);
        logic [31:0] g;
        logic [31:0] x;
        logic [31:0] y;
        for (int i = 0; i < count; i++) begin
            g = $urandom_range(1, 65535);
            x = $urandom_range(0, 32'(OP_MAX) / g);
            y = $urandom_range(0, 32'(OP_MAX) / g);
            send_operands(OPW'(g * x), OPW'(g * y));
        end
    endtask

    task automatic test_fibonacci_chains(int count);
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] scale;
        int          k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(2, 46);
            hi = fibonacci(k);
            lo = fibonacci(k - 1);
            scale = 64'($urandom_range(1, 64));
            if (hi * scale > 64'(OP_MAX))
                scale = 64'd1;
            if ($urandom_range(0, 1) == 0)
                send_operands(OPW'(hi * scale), OPW'(lo * scale));
            else
                send_operands(OPW'(lo * scale), OPW'(hi * scale));
        end
    endtask

    task automatic test_degenerate_mix(int count);
        logic [OPW-1:0] v;
        for (int i = 0; i < count; i++) begin
            v = random_operand();
            case ($urandom_range(0, 3))
                0: send_operands(v, '0);
                1: send_operands('0, v);
                2: send_operands(v, v);
                default: send_operands(v, OPW'(1));
            endcase
        end
    endtask

    // receiver stalls follow phases of varying density
    always @(negedge aclk) begin
        if (ready_phase_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_phase_left = $urandom_range(20, 400);
        end
        ready_phase_left--;
        if (!aresetn)
            m_ready <= 1'b0;
        else
            case (ready_mode)
                RDY_ALWAYS: m_ready <= 1'b1;
                RDY_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RDY_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
                default:    m_ready <= ($urandom_range(0, 63) == 0);
            endcase
    end

    // result check first, then queue the prediction for a beat taken at this edge
    always @(posedge aclk) begin : result_check
        bezout_expect_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_coefs.size() == 0) begin
                $display("%0t: unexpected result beat: bezout_s=%0d gcd=%0d",
                         $time, $signed(m_bezout_s), m_gcd_value);
                error_count++;
            end else begin
                want = expected_coefs.pop_front();
                if (m_bezout_s !== want.coef) begin
                    $display("%0t: bezout_s a=%0d b=%0d: expected %0d, got %0d",
                             $time, want.a, want.b, $signed(want.coef), $signed(m_bezout_s));
                    error_count++;
                end
                if (m_gcd_value !== want.gcd) begin
                    $display("%0t: gcd_value a=%0d b=%0d: expected %0d, got %0d",
                             $time, want.a, want.b, want.gcd, m_gcd_value);
                    error_count++;
                end
            end
        end
        if (aresetn && s_valid && s_ready)
            expected_coefs.insert(expected_coefs.size(),
                                  predict_bezout(s_operand_a, s_operand_b));
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_zero_operands();
        test_extremes();
        test_fibonacci_worst();
        test_random_operands(200);
        test_small_operands(60);
        test_shared_factor(50);
        test_fibonacci_chains(25);
        test_degenerate_mix(15);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_coefs.size() != 0)
            @(posedge aclk);
        repeat (1600) @(posedge aclk);
        if (expected_coefs.size() != 0) begin
            $display("%0t: %0d results still outstanding", $time, expected_coefs.size());
            error_count++;
        end
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
